// ===== sv/gcc_pkg.sv =====
package gcc_pkg;

   // Graph size bound: adjacency rows, row width and vertex index width follow from it.
   localparam int MAX_VERTEX_COUNT = 64;
   localparam int ROW_W            = MAX_VERTEX_COUNT;
   localparam int IDX_W            = $clog2(MAX_VERTEX_COUNT);
   localparam int CNT_W            = $clog2(MAX_VERTEX_COUNT + 1);

   localparam int VERTEX_W         = 7;
   localparam int REACH_SAT        = 127;
   localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [VERTEX_W-1:0] first_vertex;
      logic [VERTEX_W-1:0] second_vertex;
   } req_type;

   typedef struct packed {
      logic                connected;
      logic [VERTEX_W-1:0] reached_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_A,
      ST_ADD_B,
      ST_WALK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] raddr;
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [ROW_W-1:0] wdata;
      logic             clear;
   } mem_req_type;

   // Index of the lowest set bit (zero when none set).
   function automatic logic [IDX_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== sv/graph_connectivity_check_core.sv =====
// Channel   Dir  Handshake              Payload
// request   in   req_valid / req_stall  req_data  (op, first_vertex, second_vertex)
// response  out  rsp_valid / rsp_stall  rsp_data  (connected, reached_count)
// csr       in   psel/penable/pwrite    paddr, pwdata -> prdata (pready tied high)
//
// Add request: one row read-modify-write per endpoint, in ST_ADD_A then ST_ADD_B; next request in ST_ADD_B.
// Check request: the next request waits until the walk drains and the result is handed
//   off (each popped vertex's row is merged in the cycle after its pop).
// Reset clears the row valid bits, so the matrix reads empty at once; no clearing pass.
// A finished check waits in the output register while adds keep flowing; a second
//   result holds the walk in its last state until rsp_stall drops.
module graph_connectivity_check_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gcc_pkg::req_type                    req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gcc_pkg::rsp_type                    rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gcc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [gcc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [gcc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   logic [gcc_pkg::VERTEX_W-1:0] vertex_count_ff;
   logic [gcc_pkg::VERTEX_W-1:0] vertex_count_in;
   logic                         csr_write;
   logic [0:0]                   csr_index;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   gcc_pkg::rsp_type             rsp_data_ff;
   gcc_pkg::rsp_type             rsp_data_in;
   logic                         out_free;

   logic                         res_valid;
   gcc_pkg::rsp_type             res_data;
   gcc_pkg::mem_req_type         mem_req;
   logic [gcc_pkg::ROW_W-1:0]    mem_rdata;

   // ---- configuration registers ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2:2];   // word index; byte offset ignored

   always_comb begin
      vertex_count_in = vertex_count_ff;
      prdata          = '0;
      unique case (csr_index)
         gcc_pkg::REG_VERTEX_COUNT: begin
            prdata = gcc_pkg::CSR_DATA_W'(vertex_count_ff);
            if (csr_write) begin
               vertex_count_in = pwdata[gcc_pkg::VERTEX_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= gcc_pkg::VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // ---- output register: decouples the walk from a stalled consumer ----
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- sequencer and walk ----
   gcc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .vertex_count (vertex_count_ff),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata)
   );

   // ---- adjacency matrix, one row per vertex ----
   gcc_adj_mem u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

// ===== sv/gcc_adj_mem.sv =====
module gcc_adj_mem (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gcc_pkg::mem_req_type                   mem_req,
   output logic [gcc_pkg::ROW_W-1:0]              rdata
);

   logic [gcc_pkg::ROW_W-1:0]            mem [gcc_pkg::MAX_VERTEX_COUNT];
   logic [gcc_pkg::MAX_VERTEX_COUNT-1:0] row_valid_ff;
   logic [gcc_pkg::MAX_VERTEX_COUNT-1:0] row_valid_in;
   logic [gcc_pkg::ROW_W-1:0]            rd_raw_ff;
   logic [gcc_pkg::ROW_W-1:0]            byp_data_ff;
   logic                                 byp_hit_ff;
   logic                                 rd_valid_ff;

   // Array storage, one write and one read port.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_raw_ff <= mem[mem_req.raddr];
   end

   // Same-cycle write to the read row wins (write-first).
   always_ff @(posedge clock) begin
      byp_data_ff <= mem_req.wdata;
      byp_hit_ff  <= mem_req.we && (mem_req.waddr == mem_req.raddr);
      rd_valid_ff <= row_valid_ff[mem_req.raddr];
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (mem_req.clear) begin
         row_valid_in = '0;
      end else if (mem_req.we) begin
         row_valid_in[mem_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   // Rows never written since the last clear read as empty.
   assign rdata = byp_hit_ff  ? byp_data_ff :
                  rd_valid_ff ? rd_raw_ff   : '0;

endmodule

// ===== sv/gcc_ctrl.sv =====
module gcc_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  gcc_pkg::req_type                     req_data,
   output logic                                 req_stall,
   input  logic [gcc_pkg::VERTEX_W-1:0]         vertex_count,
   input  logic                                 out_free,
   output logic                                 res_valid,
   output gcc_pkg::rsp_type                     res_data,
   output gcc_pkg::mem_req_type                 mem_req,
   input  logic [gcc_pkg::ROW_W-1:0]            mem_rdata
);

   gcc_pkg::state_type               state_ff;
   gcc_pkg::state_type               state_in;
   logic [gcc_pkg::IDX_W-1:0]        a_ff;
   logic [gcc_pkg::IDX_W-1:0]        a_in;
   logic [gcc_pkg::IDX_W-1:0]        b_ff;
   logic [gcc_pkg::IDX_W-1:0]        b_in;
   logic                             edge_ok_ff;
   logic                             edge_ok_in;
   logic [gcc_pkg::ROW_W-1:0]        visited_ff;
   logic [gcc_pkg::ROW_W-1:0]        visited_in;
   logic [gcc_pkg::ROW_W-1:0]        pending_ff;
   logic [gcc_pkg::ROW_W-1:0]        pending_in;
   logic                             inflight_ff;
   logic                             inflight_in;
   logic [gcc_pkg::CNT_W-1:0]        count_ff;
   logic [gcc_pkg::CNT_W-1:0]        count_in;

   logic [gcc_pkg::VERTEX_W-1:0]     n_eff;
   logic [gcc_pkg::ROW_W-1:0]        live_mask;
   logic                             accept_ok;
   logic                             accept;
   logic                             req_edge_ok;
   logic [gcc_pkg::IDX_W-1:0]        req_a_idx;
   logic [gcc_pkg::IDX_W-1:0]        req_b_idx;
   logic [gcc_pkg::IDX_W-1:0]        next_v;
   logic                             issue;
   logic [gcc_pkg::ROW_W-1:0]        fresh;
   logic                             walk_done;

   // Effective vertex count and the mask of live vertices.
   always_comb begin
      if (vertex_count == '0) begin
         n_eff = gcc_pkg::VERTEX_W'(1);
      end else if (32'(vertex_count) > gcc_pkg::MAX_VERTEX_COUNT) begin
         n_eff = gcc_pkg::VERTEX_W'(gcc_pkg::MAX_VERTEX_COUNT);
      end else begin
         n_eff = vertex_count;
      end
      for (int i = 0; i < gcc_pkg::ROW_W; i++) begin
         live_mask[i] = (i < 32'(n_eff));
      end
   end

   assign accept_ok = (state_ff == gcc_pkg::ST_IDLE) || (state_ff == gcc_pkg::ST_ADD_B);
   assign req_stall = !accept_ok;
   assign accept    = req_valid && accept_ok;

   assign req_edge_ok = (req_data.first_vertex != '0) && (req_data.first_vertex <= n_eff) &&
                        (req_data.second_vertex != '0) && (req_data.second_vertex <= n_eff);
   assign req_a_idx   = gcc_pkg::IDX_W'(req_data.first_vertex - 7'd1);
   assign req_b_idx   = gcc_pkg::IDX_W'(req_data.second_vertex - 7'd1);

   // Walk: pop one pending vertex a cycle, merge its row in the cycle after the pop.
   assign next_v    = gcc_pkg::lowest_set(pending_ff);
   assign issue     = (state_ff == gcc_pkg::ST_WALK) && (pending_ff != '0);
   assign fresh     = inflight_ff ? (mem_rdata & live_mask & ~visited_ff) : '0;
   assign walk_done = (pending_ff == '0) && !inflight_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         gcc_pkg::ST_IDLE, gcc_pkg::ST_ADD_B: begin
            if (accept) begin
               state_in = (req_data.op == gcc_pkg::OP_ADD) ? gcc_pkg::ST_ADD_A
                                                           : gcc_pkg::ST_WALK;
            end else begin
               state_in = gcc_pkg::ST_IDLE;
            end
         end
         gcc_pkg::ST_ADD_A: begin
            state_in = gcc_pkg::ST_ADD_B;
         end
         gcc_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = gcc_pkg::ST_RESULT;
            end
         end
         gcc_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = gcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: memory port and result
   always_comb begin
      mem_req.raddr = next_v;
      mem_req.we    = 1'b0;
      mem_req.waddr = a_ff;
      mem_req.wdata = mem_rdata | (gcc_pkg::ROW_W'(1) << b_ff);
      mem_req.clear = 1'b0;
      res_valid     = 1'b0;
      unique case (state_ff)
         gcc_pkg::ST_IDLE: begin
            if (accept) begin
               mem_req.raddr = req_a_idx;
            end
         end
         gcc_pkg::ST_ADD_A: begin
            mem_req.raddr = b_ff;
            mem_req.we    = edge_ok_ff;
         end
         gcc_pkg::ST_ADD_B: begin
            if (accept) begin
               mem_req.raddr = req_a_idx;
            end
            mem_req.we    = edge_ok_ff;
            mem_req.waddr = b_ff;
            mem_req.wdata = mem_rdata | (gcc_pkg::ROW_W'(1) << a_ff);
         end
         gcc_pkg::ST_WALK: begin
            mem_req.raddr = next_v;
         end
         gcc_pkg::ST_RESULT: begin
            res_valid     = out_free;
            mem_req.clear = out_free;
         end
         default: begin
            mem_req.raddr = next_v;
         end
      endcase
      res_data.connected = (32'(count_ff) == 32'(n_eff));
      res_data.reached_count = (32'(count_ff) > gcc_pkg::REACH_SAT)
                               ? gcc_pkg::VERTEX_W'(gcc_pkg::REACH_SAT)
                               : gcc_pkg::VERTEX_W'(count_ff);
   end

   // Datapath next values
   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      edge_ok_in  = edge_ok_ff;
      visited_in  = visited_ff;
      pending_in  = pending_ff;
      inflight_in = 1'b0;
      count_in    = count_ff;
      if (accept) begin
         a_in       = req_a_idx;
         b_in       = req_b_idx;
         edge_ok_in = req_edge_ok && (req_data.op == gcc_pkg::OP_ADD);
         if (req_data.op == gcc_pkg::OP_CHECK) begin
            visited_in = gcc_pkg::ROW_W'(1);
            pending_in = gcc_pkg::ROW_W'(1);
            count_in   = '0;
         end
      end else if (state_ff == gcc_pkg::ST_WALK) begin
         visited_in  = visited_ff | fresh;
         pending_in  = (pending_ff & ~(issue ? (gcc_pkg::ROW_W'(1) << next_v) : '0)) | fresh;
         inflight_in = issue;
         count_in    = count_ff + gcc_pkg::CNT_W'(issue);
      end else if ((state_ff == gcc_pkg::ST_RESULT) && out_free) begin
         visited_in = '0;
         pending_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gcc_pkg::ST_IDLE;
         visited_ff  <= '0;
         pending_ff  <= '0;
         inflight_ff <= 1'b0;
         count_ff    <= '0;
         edge_ok_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         visited_ff  <= visited_in;
         pending_ff  <= pending_in;
         inflight_ff <= inflight_in;
         count_ff    <= count_in;
         edge_ok_ff  <= edge_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

`ifndef SYNTHESIS
   // A pending vertex has always been marked visited.
   a_pending_in_visited: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~visited_ff) == '0)
      else $error("pending vertex not in visited set");

   // The start vertex is visited throughout a walk.
   a_walk_has_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcc_pkg::ST_WALK) |-> visited_ff[0])
      else $error("walk without start vertex");

   // A result leaves only after the walk drained completely.
   a_result_after_drain: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> ((pending_ff == '0) && !inflight_ff && $past(state_ff != gcc_pkg::ST_IDLE)))
      else $error("result before walk finished");

   // The matrix is never written while a walk reads it.
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcc_pkg::ST_WALK) |-> !mem_req.we)
      else $error("matrix write during walk");
`endif

endmodule
